// ===== design/tshp_pkg.sv =====
package tshp_pkg;

	localparam int MAX_EXT_DEF = 32;

	localparam int OUT_DW = 80;
	localparam int OUT_UW = 2;

	localparam logic [5:0]  SEEN_MAX   = 6'd40;
	localparam logic [5:0]  RUN_CAP    = 6'd32;
	localparam logic [16:0] OFF_MAX    = 17'h1ffff;
	localparam logic [15:0] SV_TYPE    = 16'h002b;
	localparam logic [3:0]  GREASE_NIB = 4'ha;

	typedef struct packed {
		logic take;
		logic rd;
		logic load;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic last;
	} sts_t;

	function automatic logic grease_type(input logic [15:0] t);
		return (t[15:8] == t[7:0]) && (t[3:0] == GREASE_NIB);
	endfunction

endpackage

// ===== design/tshp_ctrl.sv =====
module tshp_ctrl
	import tshp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tlast,
	output logic s_tready,
	input  logic m_tready,
	output logic m_tvalid,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       m_tvalid_q;
	logic       slot_free;

	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = s_tvalid;
				if (s_tvalid && s_tlast) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (slot_free) begin
					cmd.load = 1'b1;
					if (sts.last) begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/tshp_dpath.sv =====
module tshp_dpath
	import tshp_pkg::*;
#(
	parameter int MAX_EXTENSIONS = MAX_EXT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [7:0]        in_byte,
	output logic [OUT_DW-1:0] out_data,
	output logic [OUT_UW-1:0] out_user,
	output logic              out_last
);

	localparam int AW = (MAX_EXTENSIONS > 1) ? $clog2(MAX_EXTENSIONS) : 1;
	localparam int CW = $clog2(MAX_EXTENSIONS + 1);

	localparam logic [3:0] PH_VER    = 4'd0;
	localparam logic [3:0] PH_RAND   = 4'd1;
	localparam logic [3:0] PH_SIDLEN = 4'd2;
	localparam logic [3:0] PH_SID    = 4'd3;
	localparam logic [3:0] PH_CIPHER = 4'd4;
	localparam logic [3:0] PH_COMP   = 4'd5;
	localparam logic [3:0] PH_EXTLEN = 4'd6;
	localparam logic [3:0] PH_HDR    = 4'd7;
	localparam logic [3:0] PH_BODY   = 4'd8;
	localparam logic [3:0] PH_SKIP   = 4'd9;

	logic [3:0]    phase_q, phase_d;
	logic [15:0]   pcnt_q, pcnt_d;
	logic [5:0]    seen_q, seen_d;
	logic [15:0]   legv_q, legv_d;
	logic [15:0]   ciph_q, ciph_d;
	logic [15:0]   chv_q, chv_d;
	logic [15:0]   blen_q, blen_d;
	logic [16:0]   boff_q, boff_d;
	logic [15:0]   ctype_q, ctype_d;
	logic [15:0]   clen_q, clen_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          ovf_q, ovf_d;
	logic          err_q, err_d;
	logic          st_we;
	logic [4:0]    idx_q;

	logic [15:0]   store_mem [MAX_EXTENSIONS];
	logic [15:0]   rd_q;

	logic [OUT_DW-1:0] out_data_q;
	logic [OUT_UW-1:0] out_user_q;
	logic              out_last_q;

	logic        msg_ok;
	logic [6:0]  cnt_w;
	logic [5:0]  run_len;
	logic        has;

	always_comb begin
		logic [16:0] pc1;
		logic [15:0] len_new;
		logic [15:0] blen_new;
		logic [17:0] hdr_end;
		logic [17:0] body_end;

		phase_d = phase_q;
		pcnt_d  = pcnt_q;
		seen_d  = seen_q;
		legv_d  = legv_q;
		ciph_d  = ciph_q;
		chv_d   = chv_q;
		blen_d  = blen_q;
		boff_d  = boff_q;
		ctype_d = ctype_q;
		clen_d  = clen_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		err_d   = err_q;
		st_we   = 1'b0;

		pc1      = {1'b0, pcnt_q} + 17'd1;
		len_new  = {clen_q[7:0], in_byte};
		blen_new = {blen_q[7:0], in_byte};
		hdr_end  = {1'b0, boff_q} + 18'd1;
		body_end = hdr_end + {2'b00, len_new};

		if (cmd.clear) begin
			phase_d = PH_VER;
			pcnt_d  = '0;
			seen_d  = '0;
			legv_d  = '0;
			ciph_d  = '0;
			chv_d   = '0;
			blen_d  = '0;
			boff_d  = '0;
			ctype_d = '0;
			clen_d  = '0;
			cnt_d   = '0;
			ovf_d   = 1'b0;
			err_d   = 1'b0;
		end else if (cmd.take) begin
			if (seen_q < SEEN_MAX) begin
				seen_d = seen_q + 6'd1;
			end
			unique case (phase_q)
				PH_VER: begin
					legv_d = {legv_q[7:0], in_byte};
					if (pc1 == 17'd2) begin
						phase_d = PH_RAND;
						pcnt_d  = '0;
					end else begin
						pcnt_d = pc1[15:0];
					end
				end
				PH_RAND: begin
					if (pc1 == 17'd32) begin
						phase_d = PH_SIDLEN;
						pcnt_d  = '0;
					end else begin
						pcnt_d = pc1[15:0];
					end
				end
				PH_SIDLEN: begin
					clen_d  = {8'h00, in_byte};
					pcnt_d  = '0;
					phase_d = (in_byte == 8'h00) ? PH_CIPHER : PH_SID;
				end
				PH_SID: begin
					if (pc1 >= {1'b0, clen_q}) begin
						phase_d = PH_CIPHER;
						pcnt_d  = '0;
					end else begin
						pcnt_d = pc1[15:0];
					end
				end
				PH_CIPHER: begin
					ciph_d = {ciph_q[7:0], in_byte};
					if (pc1 == 17'd2) begin
						phase_d = PH_COMP;
						pcnt_d  = '0;
					end else begin
						pcnt_d = pc1[15:0];
					end
				end
				PH_COMP: begin
					phase_d = PH_EXTLEN;
					pcnt_d  = '0;
				end
				PH_EXTLEN: begin
					blen_d = blen_new;
					if (pc1 == 17'd2) begin
						boff_d  = '0;
						err_d   = (blen_new != 16'h0000);
						pcnt_d  = '0;
						phase_d = (blen_new >= 16'd4) ? PH_HDR : PH_SKIP;
					end else begin
						pcnt_d = pc1[15:0];
					end
				end
				PH_HDR: begin
					if (pcnt_q < 16'd2) begin
						ctype_d = {ctype_q[7:0], in_byte};
					end else begin
						clen_d = len_new;
					end
					if (pc1 == 17'd4) begin
						pcnt_d = '0;
						if (body_end > {2'b00, blen_q}) begin
							phase_d = PH_SKIP;
						end else begin
							if (!grease_type(ctype_q)) begin
								if (cnt_q < CW'(MAX_EXTENSIONS)) begin
									st_we = 1'b1;
									cnt_d = cnt_q + CW'(1);
								end else begin
									ovf_d = 1'b1;
								end
							end
							if (len_new == 16'h0000) begin
								phase_d = ((hdr_end + 18'd4) <= {2'b00, blen_q}) ?
									PH_HDR : PH_SKIP;
							end else begin
								phase_d = PH_BODY;
							end
						end
					end else begin
						pcnt_d = pc1[15:0];
					end
				end
				PH_BODY: begin
					if (ctype_q == SV_TYPE && clen_q == 16'd2) begin
						if (pcnt_q == 16'h0000) begin
							chv_d = {in_byte, chv_q[7:0]};
						end else begin
							chv_d = {chv_q[15:8], in_byte};
						end
					end
					if (pc1 >= {1'b0, clen_q}) begin
						pcnt_d  = '0;
						phase_d = ((hdr_end + 18'd4) <= {2'b00, blen_q}) ?
							PH_HDR : PH_SKIP;
					end else begin
						pcnt_d = pc1[15:0];
					end
				end
				default: begin
				end
			endcase
			if (phase_q >= PH_HDR && boff_q < OFF_MAX) begin
				boff_d = hdr_end[16:0];
				if (hdr_end >= {2'b00, blen_q}) begin
					err_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VER;
			pcnt_q  <= '0;
			seen_q  <= '0;
			legv_q  <= '0;
			ciph_q  <= '0;
			chv_q   <= '0;
			blen_q  <= '0;
			boff_q  <= '0;
			ctype_q <= '0;
			clen_q  <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			err_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pcnt_q  <= pcnt_d;
			seen_q  <= seen_d;
			legv_q  <= legv_d;
			ciph_q  <= ciph_d;
			chv_q   <= chv_d;
			blen_q  <= blen_d;
			boff_q  <= boff_d;
			ctype_q <= ctype_d;
			clen_q  <= clen_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
			err_q   <= err_d;
			if (cmd.load) begin
				idx_q <= sts.last ? 5'd0 : (idx_q + 5'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[AW'(cnt_q)] <= ctype_q;
		end
		if (cmd.rd) begin
			rd_q <= store_mem[AW'(idx_q)];
		end
	end

	// result of the run: message check and entry selection
	assign msg_ok  = (seen_q >= SEEN_MAX) && (phase_q >= PH_HDR) && !err_q &&
		(boff_q >= {1'b0, blen_q});
	assign cnt_w   = 7'(cnt_q);
	assign run_len = (cnt_w < {1'b0, RUN_CAP}) ? cnt_w[5:0] : RUN_CAP;
	assign has     = ({1'b0, idx_q} < run_len);
	assign sts.last = !msg_ok || (({1'b0, idx_q} + 6'd1) >= run_len);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (msg_ok) begin
				out_data_q <= {4'h0,
					has ? idx_q : 5'd0,
					has ? rd_q : 16'h0000,
					ovf_q,
					cnt_w[5:0],
					chv_q,
					ciph_q,
					legv_q};
				out_user_q <= {has, 1'b1};
			end else begin
				out_data_q <= '0;
				out_user_q <= '0;
			end
			// an invalid message gives one all-zero transfer, tlast included
			out_last_q <= msg_ok && sts.last;
		end
	end

	assign out_data = out_data_q;
	assign out_user = out_user_q;
	assign out_last = out_last_q;

endmodule

// ===== design/tls_server_hello_parser.sv =====
// ServerHello body parser.
// Input stream s_*: one body byte per transfer, starting at the legacy
// version; s_tlast marks the final byte of a message. Bytes are taken at
// one per cycle while a message is being parsed.
// Output stream m_*: after the final byte, a run of 1 to 32 result
// transfers (one per stored extension type, or one when none are stored or
// the message is invalid); m_tlast marks the last result of a valid message.
// An invalid message gives a single all-zero transfer with m_tlast low.
// The first result follows the final byte's transfer after a type store read and an output register load.
// Each result takes a read of the type store, then a load of the
// output register. s_tready stays low from the final byte until the last
// result of the run has been loaded into the output register.
// When m_tready is low the output register holds its transfer and the run
// waits; the next message's bytes are accepted once the last result is loaded.
// Reset clears the parser and any pending output; the type store is not
// cleared, and an entry not written for the current message may be read but is not output.
module tls_server_hello_parser
	import tshp_pkg::*;
#(
	parameter int MAX_EXTENSIONS = MAX_EXT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // data_byte
	input  logic              s_tlast,   // end_of_message
	output logic              m_tvalid,
	input  logic              m_tready,
	// legacy_version, cipher_suite, chosen_version, extension_count, overflow,
	// extension_type, entry_index, zero pad
	output logic [OUT_DW-1:0] m_tdata,
	output logic [OUT_UW-1:0] m_tuser,   // valid_res, entry_present
	output logic              m_tlast    // last_of_run
);

	cmd_t cmd;
	sts_t sts;

	tshp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd),
		.sts      (sts)
	);

	tshp_dpath #(
		.MAX_EXTENSIONS (MAX_EXTENSIONS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_byte  (s_tdata),
		.out_data (m_tdata),
		.out_user (m_tuser),
		.out_last (m_tlast)
	);

endmodule

// ===== sim/tb_top.sv =====
module tb_top
	import tshp_pkg::*;
;

	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          BYTE_TARGET   = 480;
	localparam int          MIN_BODY      = 40;
	localparam int          STORE_DEPTH   = 32;
	localparam int          RUN_LIMIT     = 32;
	localparam logic [16:0] OFFSET_LIMIT  = 17'h1ffff;
	localparam logic [15:0] SUPPORTED_VER = 16'h002b;
	localparam logic [3:0]  GREASE_LOW    = 4'ha;

	typedef enum logic [3:0] {
		P_VERSION, P_RANDOM, P_SID_LEN, P_SID, P_CIPHER,
		P_COMP, P_EXT_LEN, P_HDR, P_BODY, P_SKIP
	} hello_phase_t;

	typedef struct packed {
		logic        valid_res;
		logic [15:0] legacy_ver;
		logic [15:0] cipher_suite;
		logic [15:0] chosen_version;
		logic [5:0]  extension_count;
		logic        overflow;
		logic [15:0] extension_type;
		logic        entry_present;
		logic [4:0]  entry_index;
		logic        last_of_run;
	} hello_result_t;

	class hello_scoreboard;
		hello_result_t pending[$];
		int            errors;

		hello_phase_t  phase;
		logic [15:0]   pos;
		logic [5:0]    seen;
		logic [15:0]   ver;
		logic [15:0]   cipher;
		logic [15:0]   chosen;
		logic [15:0]   blk_len;
		logic [16:0]   offset;
		logic [15:0]   cur_type;
		logic [15:0]   cur_len;
		logic [15:0]   types[STORE_DEPTH];
		logic [5:0]    count;
		logic          ovf;
		logic          err;

		function new();
			errors = 0;
			clear_msg();
		endfunction

		function void clear_msg();
			phase = P_VERSION;
			pos = '0;
			seen = '0;
			ver = '0;
			cipher = '0;
			chosen = '0;
			blk_len = '0;
			offset = '0;
			cur_type = '0;
			cur_len = '0;
			count = '0;
			ovf = 1'b0;
			err = 1'b0;
		endfunction

		function void next_header(logic [17:0] start);
			pos = '0;
			phase = (start + 4 <= blk_len) ? P_HDR : P_SKIP;
		endfunction

		// advance the parse by one body byte; on the final byte queue the run
		function void note_byte(logic [7:0] b, logic last);
			logic [16:0]   off;
			logic [17:0]   stop;
			logic          len_byte;
			logic          ok;
			int            n;
			int            k;
			hello_result_t r;

			if (seen < MIN_BODY) seen++;
			off = offset;
			len_byte = (phase == P_EXT_LEN);
			case (phase)
				P_VERSION: begin
					ver = {ver[7:0], b};
					pos++;
					if (pos == 2) begin
						phase = P_RANDOM;
						pos = '0;
					end
				end
				P_RANDOM: begin
					pos++;
					if (pos == 32) begin
						phase = P_SID_LEN;
						pos = '0;
					end
				end
				P_SID_LEN: begin
					cur_len = {8'h00, b};
					pos = '0;
					phase = (b == 8'h00) ? P_CIPHER : P_SID;
				end
				P_SID: begin
					pos++;
					if (pos >= cur_len) begin
						phase = P_CIPHER;
						pos = '0;
					end
				end
				P_CIPHER: begin
					cipher = {cipher[7:0], b};
					pos++;
					if (pos == 2) begin
						phase = P_COMP;
						pos = '0;
					end
				end
				P_COMP: begin
					phase = P_EXT_LEN;
					pos = '0;
				end
				P_EXT_LEN: begin
					blk_len = {blk_len[7:0], b};
					pos++;
					if (pos == 2) begin
						offset = '0;
						err = (blk_len != 0);
						next_header(18'd0);
					end
				end
				P_HDR: begin
					if (pos < 2) cur_type = {cur_type[7:0], b};
					else cur_len = {cur_len[7:0], b};
					pos++;
					if (pos == 4) begin
						stop = off + 1;
						if (stop + cur_len > blk_len) begin
							phase = P_SKIP;
							pos = '0;
						end else begin
							if (!(cur_type[15:8] == cur_type[7:0] &&
								cur_type[3:0] == GREASE_LOW)) begin
								if (count < STORE_DEPTH) begin
									types[count] = cur_type;
									count++;
								end else begin
									ovf = 1'b1;
								end
							end
							if (cur_len == 0) begin
								next_header(stop);
							end else begin
								phase = P_BODY;
								pos = '0;
							end
						end
					end
				end
				P_BODY: begin
					if (cur_type == SUPPORTED_VER && cur_len == 2) begin
						if (pos == 0) chosen[15:8] = b;
						else chosen[7:0] = b;
					end
					pos++;
					if (pos >= cur_len) next_header(off + 1);
				end
				default: ;
			endcase

			if (!len_byte && phase >= P_HDR && off < OFFSET_LIMIT) begin
				offset = off + 1;
				if (offset >= blk_len) err = 1'b0;
			end

			if (!last) return;

			ok = seen >= MIN_BODY && phase >= P_HDR && !err && offset >= blk_len;
			if (!ok) begin
				r = '0;
				pending = {pending, r};
			end else begin
				n = (count < RUN_LIMIT) ? int'(count) : RUN_LIMIT;
				k = 0;
				do begin
					r.valid_res = 1'b1;
					r.legacy_ver = ver;
					r.cipher_suite = cipher;
					r.chosen_version = chosen;
					r.extension_count = count;
					r.overflow = ovf;
					r.extension_type = (k < n) ? types[k] : 16'h0000;
					r.entry_present = (k < n);
					r.entry_index = (k < n) ? k[4:0] : 5'd0;
					r.last_of_run = (k + 1 >= n);
					pending = {pending, r};
					k++;
				end while (k < n);
			end
			clear_msg();
		endfunction

		function void cmp(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_DW-1:0] d, logic [OUT_UW-1:0] u, logic l);
			hello_result_t e;

			if (pending.size() == 0) begin
				$error("result transfer with nothing pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp("valid_res", 16'(e.valid_res), 16'(u[0]));
			cmp("legacy_version", e.legacy_ver, d[15:0]);
			cmp("cipher_suite", e.cipher_suite, d[31:16]);
			cmp("chosen_version", e.chosen_version, d[47:32]);
			cmp("extension_count", 16'(e.extension_count), 16'(d[53:48]));
			cmp("overflow", 16'(e.overflow), 16'(d[54]));
			cmp("extension_type", e.extension_type, d[70:55]);
			cmp("entry_present", 16'(e.entry_present), 16'(u[1]));
			cmp("entry_index", 16'(e.entry_index), 16'(d[75:71]));
			cmp("last_of_run", 16'(e.last_of_run), 16'(l));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_DW-1:0] m_tdata;
	logic [OUT_UW-1:0] m_tuser;
	logic              m_tlast;

	hello_scoreboard sb = new();
	int unsigned     idle_pct;
	int unsigned     stall_pct;
	int              cycle_count = 0;
	int              sent_bytes = 0;
	int              msg_num = 0;
	logic [7:0]      blk[$];
	logic [7:0]      msg[$];

	tls_server_hello_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// extension header claiming len body bytes, of which body are sent
	function automatic void add_ext(logic [15:0] t, int len, int body);
		logic [15:0] l;

		l = len[15:0];
		blk = {blk, t[15:8], t[7:0], l[15:8], l[7:0]};
		repeat (body) blk = {blk, 8'($urandom)};
	endfunction

	function automatic void add_fill(int n);
		repeat (n) blk = {blk, 8'($urandom)};
	endfunction

	function automatic void add_rand_ext();
		logic [7:0]  g;
		logic [15:0] t;
		int          len;

		case ($urandom_range(7))
			0: begin
				g = {4'($urandom), GREASE_LOW};
				t = {g, g};
				len = $urandom_range(0, 2);
			end
			1: begin
				t = SUPPORTED_VER;
				len = 2;
			end
			2: begin
				t = SUPPORTED_VER;
				len = $urandom_range(0, 4);
			end
			default: begin
				t = 16'($urandom);
				len = $urandom_range(0, 6);
			end
		endcase
		add_ext(t, len, len);
	endfunction

	// header, session id, extension block length (given or from blk), blk, trailing bytes
	function automatic void wrap_hello(int sid_len, int trailing, int ext_len = -1);
		logic [15:0] l;

		l = (ext_len < 0) ? 16'(blk.size()) : ext_len[15:0];
		msg.delete();
		repeat (34) msg = {msg, 8'($urandom)};
		msg = {msg, sid_len[7:0]};
		repeat (sid_len) msg = {msg, 8'($urandom)};
		repeat (3) msg = {msg, 8'($urandom)};
		msg = {msg, l[15:8], l[7:0]};
		msg = {msg, blk};
		repeat (trailing) msg = {msg, 8'($urandom)};
		blk.delete();
	endfunction

	function automatic void random_hello();
		int n_ext;
		int k;

		n_ext = $urandom_range(0, 5);
		repeat (n_ext) add_rand_ext();
		case ($urandom_range(5))
			0: begin
				k = $urandom_range(0, 4);
				add_ext(16'($urandom), k + 1 + $urandom_range(0, 500), k);
			end
			1: add_fill($urandom_range(1, 3));
			default: ;
		endcase
		wrap_hello(($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8),
			($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b, last);
	endtask

	// idling phases rotate per message: none, sender idle, receiver stall, both
	task automatic send_msg();
		idle_pct = (msg_num % 4 == 1) ? 49 : (msg_num % 4 == 3) ? 15 : 0;
		stall_pct = (msg_num % 4 == 2) ? 49 : (msg_num % 4 == 3) ? 15 : 0;
		foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
		sent_bytes += msg.size();
		msg_num++;
	endtask

	initial begin
		int sel;
		int cut;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest valid body, no extension block
		wrap_hello(0, 0);
		send_msg();
		// one byte short of the minimum
		wrap_hello(0, 0);
		void'(msg.pop_back());
		send_msg();
		msg.delete();
		msg = {msg, 8'hff};
		send_msg();
		// GREASE, supported version extension of both lengths, repeated
		add_ext(16'h0a0a, 0, 0);
		add_ext(SUPPORTED_VER, 2, 2);
		add_ext(16'h0000, 0, 0);
		add_ext(16'hffff, 1, 1);
		add_ext(16'hfafa, 3, 3);
		add_ext(SUPPORTED_VER, 3, 3);
		add_ext(SUPPORTED_VER, 2, 2);
		wrap_hello(0, 0);
		send_msg();
		// overrunning extension, trailing bytes
		add_ext(16'h0017, 0, 0);
		add_ext(SUPPORTED_VER, 9, 1);
		wrap_hello(0, 5);
		send_msg();
		// under four bytes left for a header
		add_ext(16'h0010, 2, 2);
		add_fill(3);
		wrap_hello(0, 0);
		send_msg();
		// store overflowing by two
		for (int i = 0; i < STORE_DEPTH + 1; i++) add_ext(16'(i + 512), 0, 0);
		add_ext(SUPPORTED_VER, 2, 2);
		wrap_hello(0, 0);
		send_msg();

		while (sent_bytes < BYTE_TARGET) begin
			sel = $urandom_range(99);
			if (sel < 70) begin
				random_hello();
			end else if (sel < 85) begin
				random_hello();
				cut = $urandom_range(1, msg.size() - 1);
				msg = msg[0:cut - 1];
			end else begin
				msg.delete();
				repeat ($urandom_range(1, 70)) msg = {msg, 8'($urandom)};
			end
			send_msg();
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
design/tshp_pkg.sv
design/tshp_ctrl.sv
design/tshp_dpath.sv
design/tls_server_hello_parser.sv
sim/tb_top.sv
